### hw/rtl/mpq_pkg.sv
package mpq_pkg;

    localparam int STATUS_W = 3;
    localparam int WORD_W   = 32;
    localparam int PRIO_W   = 2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPRIO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_rd;
    } mpq_cmd_t;

    typedef struct packed {
        logic rd_hit;
    } mpq_stat_t;

endpackage

### hw/rtl/mpq_ram.sv
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/mpq_datapath.sv
module mpq_datapath #(
    parameter int LEVELS = 3,
    parameter int DEPTH  = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mpq_pkg::mpq_cmd_t                 cmd,
    output mpq_pkg::mpq_stat_t                stat,
    input  logic                              in_func,
    input  logic [mpq_pkg::PRIO_W-1:0]        in_prio,
    input  logic signed [mpq_pkg::WORD_W-1:0] in_item,
    output logic [mpq_pkg::STATUS_W-1:0]      out_status,
    output logic signed [mpq_pkg::WORD_W-1:0] out_item,
    output logic [mpq_pkg::PRIO_W-1:0]        out_level
);
    import mpq_pkg::*;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOTS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    logic                     req_func_reg;
    logic [PRIO_W-1:0]        req_prio_reg;
    logic signed [WORD_W-1:0] req_item_reg;

    logic [CNT_W-1:0] fill_reg [LEVELS];
    logic [CNT_W-1:0] fill_next [LEVELS];
    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];

    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [WORD_W-1:0] item_reg, item_next;
    logic [PRIO_W-1:0]        level_reg, level_next;

    logic              bad_prio;
    logic [LVL_W-1:0]  ins_lvl;
    logic              ins_full;
    logic              found;
    logic [LVL_W-1:0]  del_lvl;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_rdata;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        bad_prio = (32'(req_prio_reg) >= LEVELS);
        ins_lvl  = bad_prio ? '0 : LVL_W'(req_prio_reg);
        ins_full = (fill_reg[ins_lvl] == CNT_W'(DEPTH));
        found    = 1'b0;
        del_lvl  = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (!found && fill_reg[i] != '0) begin
                found   = 1'b1;
                del_lvl = LVL_W'(i);
            end
        end
    end

    always_comb begin
        fill_next   = fill_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = status_reg;
        item_next   = item_reg;
        level_next  = level_reg;
        ram_we      = 1'b0;
        ram_addr    = ADDR_W'(ins_lvl) * ADDR_W'(DEPTH) + ADDR_W'(tail_reg[ins_lvl]);
        stat.rd_hit = (req_func_reg == FUNC_DELETE) && found;
        if (req_func_reg == FUNC_DELETE) begin
            ram_addr = ADDR_W'(del_lvl) * ADDR_W'(DEPTH) + ADDR_W'(head_reg[del_lvl]);
        end
        if (cmd.exec) begin
            item_next = '0;
            if (req_func_reg == FUNC_INSERT) begin
                level_next = req_prio_reg;
                priority if (bad_prio) begin
                    status_next = ST_BADPRIO;
                end else if (ins_full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    status_next        = ST_INSERTED;
                    ram_we             = 1'b1;
                    tail_next[ins_lvl] = wrap_inc(tail_reg[ins_lvl]);
                    fill_next[ins_lvl] = fill_reg[ins_lvl] + 1'b1;
                end
            end else if (found) begin
                status_next        = ST_DELETED;
                level_next         = PRIO_W'(del_lvl);
                head_next[del_lvl] = wrap_inc(head_reg[del_lvl]);
                fill_next[del_lvl] = fill_reg[del_lvl] - 1'b1;
            end else begin
                status_next = ST_EMPTY;
                level_next  = '0;
            end
        end
        if (cmd.load_rd) begin
            item_next = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            fill_reg <= fill_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_func_reg <= in_func;
            req_prio_reg <= in_prio;
            req_item_reg <= in_item;
        end
        status_reg <= status_next;
        item_reg   <= item_next;
        level_reg  <= level_next;
    end

    mpq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(req_item_reg),
        .rdata(ram_rdata)
    );

    assign out_status = status_reg;
    assign out_item   = item_reg;
    assign out_level  = level_reg;

endmodule

### hw/rtl/mpq_ctrl.sv
module mpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  mpq_pkg::mpq_stat_t stat,
    output mpq_pkg::mpq_cmd_t  cmd
);
    import mpq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load_rd = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.rd_hit ? S_RDWAIT : S_OUT;
            end
            S_RDWAIT: begin
                cmd.load_rd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

endmodule

### hw/rtl/multilevel_priority_queue.sv
// Multilevel priority queue: one ring FIFO of DEPTH words for each of LEVELS
// levels, level 0 most urgent, all levels sharing one single-port slot RAM.
// Each request on the slave channel (insert or delete, chosen by s_tuser)
// yields exactly one result on the master channel, and requests are served
// one at a time: an insert or a failed request goes from acceptance through
// S_EXEC and S_OUT, a successful delete also through S_RDWAIT for the
// registered read of the slot RAM; a stalled master holds it in S_OUT.
// Unwritten slots are never read, so the RAM needs no clearing after reset.
module multilevel_priority_queue #(
    parameter int LEVELS = 3,
    parameter int DEPTH  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // priority_req[1:0], item[33:2], zero pad
    input  logic [0:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // item_out[31:0], level_out[33:32], zero pad
    output logic [2:0]  m_tuser    // status
);
    import mpq_pkg::*;

    mpq_cmd_t               cmd;
    mpq_stat_t              stat;
    logic [STATUS_W-1:0]    out_status;
    logic signed [WORD_W-1:0] out_item;
    logic [PRIO_W-1:0]      out_level;

    mpq_datapath #(
        .LEVELS(LEVELS),
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tuser[0]),
        .in_prio   (s_tdata[1:0]),
        .in_item   (s_tdata[33:2]),
        .out_status(out_status),
        .out_item  (out_item),
        .out_level (out_level)
    );

    mpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    assign m_tdata = {6'd0, out_level, out_item};
    assign m_tuser = out_status;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result shown before the request was executed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_EMPTY))
        else $error("undefined status code");

    a_item_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DELETED) |-> (m_tdata[31:0] == '0))
        else $error("item non-zero on a result that removed nothing");

endmodule
